FILE: src/rmu_pkg.sv
`default_nettype none

package rmu_pkg;

  // sample and median width
  localparam int unsigned DATA_W = 32;
  // width of the reported sample count
  localparam int unsigned STORED_W = 11;
  // result request packed into whole bytes
  localparam int unsigned OUT_TDATA_W = 48;

  // operation broadcast to every cell of a sorted chain
  typedef enum logic [1:0] {
    OP_IDLE,
    OP_INSERT,
    OP_PUSH,
    OP_POP_INSERT
  } cell_op_t;

  typedef struct packed {
    cell_op_t                   op;
    logic signed [DATA_W-1:0]   data;
  } cell_cmd_t;

endpackage

`default_nettype wire

FILE: src/running_median_unit.sv
`default_nettype none

// Running median of a stream of signed 32-bit samples. Every sample is kept
// in two sorted rows of cells: the lower half in descending order and the
// upper half in ascending order, so both middle elements always sit in the
// first cell of a row. A sample is broadcast to all cells, which compare it
// against their value and shift or take it in parallel, so one sample is
// taken per clock while s_tready is high; a result is held pending, then
// registered. s_tready drops only while one waits at a stalled output.
// The median comes out as a floor value plus a half bit. Once CAPACITY
// samples are held, further samples are dropped with the overflow bit set
// and the previous median and count are reported. No clearing pass follows
// reset; the cells hold no meaning until filled.
module running_median_unit #(
  parameter int unsigned CAPACITY = 1024
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [rmu_pkg::DATA_W-1:0]         s_tdata,  // [31:0] sample
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // [31:0] median_floor, [32] median_half, [43:33] stored_count,
  // [44] overflow, [47:45] zero
  output logic [rmu_pkg::OUT_TDATA_W-1:0]         m_tdata
);

  localparam int unsigned HALF_DEPTH = (CAPACITY + 1) / 2;
  localparam int unsigned HC_W       = $clog2(HALF_DEPTH + 1);
  localparam int unsigned TC_W       = $clog2(CAPACITY + 1);
  localparam int unsigned DW         = rmu_pkg::DATA_W;
  localparam int unsigned SW         = rmu_pkg::STORED_W;
  localparam int unsigned PAD_W      = rmu_pkg::OUT_TDATA_W - DW - SW - 2;

  logic [HC_W-1:0]         lower_count;
  logic [HC_W-1:0]         upper_count;
  logic [HC_W-1:0]         lower_count_next;
  logic [HC_W-1:0]         upper_count_next;
  logic [TC_W-1:0]         total;
  logic                    full;
  logic                    accept;
  logic signed [DW-1:0]    sample;
  logic signed [DW-1:0]    lower_head;
  logic signed [DW-1:0]    upper_head;
  rmu_pkg::cell_cmd_t      lower_cmd;
  rmu_pkg::cell_cmd_t      upper_cmd;

  logic                    pend;
  logic                    pend_ovf;
  logic                    can_load;
  logic signed [DW:0]      mid_sum;
  logic signed [DW-1:0]    floor_val;
  logic                    half_val;

  logic signed [DW-1:0]    median_floor;
  logic                    median_half;
  logic [SW-1:0]           stored_count;
  logic                    overflow;

  assign sample   = $signed(s_tdata);
  assign total    = TC_W'(lower_count) + TC_W'(upper_count);
  assign full     = total >= TC_W'(CAPACITY);
  assign can_load = !m_tvalid || m_tready;
  assign s_tready = !pend || can_load;
  assign accept   = s_tvalid && s_tready;

  // steer the sample between the two halves
  always_comb begin
    lower_cmd        = '{op: rmu_pkg::OP_IDLE, data: sample};
    upper_cmd        = '{op: rmu_pkg::OP_IDLE, data: sample};
    lower_count_next = lower_count;
    upper_count_next = upper_count;
    if (accept && !full) begin
      if (lower_count <= upper_count) begin
        if (upper_count != '0 && sample > upper_head) begin
          lower_cmd = '{op: rmu_pkg::OP_PUSH, data: upper_head};
          upper_cmd = '{op: rmu_pkg::OP_POP_INSERT, data: sample};
        end else begin
          lower_cmd = '{op: rmu_pkg::OP_INSERT, data: sample};
        end
        lower_count_next = lower_count + 1'b1;
      end else begin
        if (sample < lower_head) begin
          lower_cmd = '{op: rmu_pkg::OP_POP_INSERT, data: sample};
          upper_cmd = '{op: rmu_pkg::OP_PUSH, data: lower_head};
        end else begin
          upper_cmd = '{op: rmu_pkg::OP_INSERT, data: sample};
        end
        upper_count_next = upper_count + 1'b1;
      end
    end
  end

  // lower half, largest first
  rmu_chain #(
    .DEPTH   (HALF_DEPTH),
    .DESCEND (1'b1),
    .CNT_W   (HC_W)
  ) u_lower (
    .clk  (clk),
    .cmd  (lower_cmd),
    .cnt  (lower_count),
    .head (lower_head)
  );

  // upper half, smallest first
  rmu_chain #(
    .DEPTH   (HALF_DEPTH),
    .DESCEND (1'b0),
    .CNT_W   (HC_W)
  ) u_upper (
    .clk  (clk),
    .cmd  (upper_cmd),
    .cnt  (upper_count),
    .head (upper_head)
  );

  // median from the middle cell, or from the two middle cells
  assign mid_sum = (DW + 1)'(lower_head) + (DW + 1)'(upper_head);

  always_comb begin
    if (total[0] || upper_count == '0) begin
      floor_val = lower_head;
      half_val  = 1'b0;
    end else begin
      floor_val = mid_sum[DW:1];
      half_val  = mid_sum[0];
    end
  end

  // counts and result pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      lower_count <= '0;
      upper_count <= '0;
      pend        <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      lower_count <= lower_count_next;
      upper_count <= upper_count_next;
      if (accept) begin
        pend <= 1'b1;
      end else if (can_load) begin
        pend <= 1'b0;
      end
      if (can_load) begin
        m_tvalid <= pend;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_ovf <= full;
    end
    if (can_load && pend) begin
      median_floor <= floor_val;
      median_half  <= half_val;
      stored_count <= SW'(total);
      overflow     <= pend_ovf;
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, overflow, stored_count, median_half, median_floor};

  // the halves stay balanced, lower one holding the extra sample
  assert property (@(posedge clk) disable iff (rst)
    (lower_count == upper_count) || (lower_count == upper_count + 1'b1))
    else $error("halves out of balance");

  // never more samples than the store holds
  assert property (@(posedge clk) disable iff (rst) total <= TC_W'(CAPACITY))
    else $error("store count beyond capacity");

  // a full store leaves the counts alone
  assert property (@(posedge clk) disable iff (rst)
    accept && full |=> $stable(lower_count) && $stable(upper_count))
    else $error("dropped sample changed the store");

  // input stalls only behind a waiting result
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> pend && m_tvalid && !m_tready)
    else $error("input stalled without cause");

  // an odd count never yields a half
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && stored_count[0] |-> !median_half)
    else $error("half bit set for odd count");

endmodule

`default_nettype wire

FILE: src/rmu_cell.sv
`default_nettype none

module rmu_cell #(
  parameter int unsigned IDX     = 0,
  parameter bit          DESCEND = 1'b1,
  parameter int unsigned CNT_W   = 10
) (
  input  wire logic                                clk,
  input  wire rmu_pkg::cell_cmd_t                  cmd,
  input  wire logic [CNT_W-1:0]                    cnt,
  input  wire logic signed [rmu_pkg::DATA_W-1:0]   prev_val,
  input  wire logic                                prev_stay,
  input  wire logic signed [rmu_pkg::DATA_W-1:0]   next_val,
  input  wire logic                                next_stay,
  output logic signed [rmu_pkg::DATA_W-1:0]        val,
  output logic                                     stay
);

  localparam bit FIRST = (IDX == 0);

  logic                               occ;
  logic                               ahead;
  logic signed [rmu_pkg::DATA_W-1:0]  val_next;

  // held value stays in front of the broadcast sample
  assign occ   = cnt > CNT_W'(IDX);
  assign ahead = DESCEND ? (val >= cmd.data) : (val <= cmd.data);
  assign stay  = occ && ahead;

  // pick own, neighbor or broadcast value
  always_comb begin
    unique case (cmd.op)
      rmu_pkg::OP_INSERT:     val_next = stay ? val : (prev_stay ? cmd.data : prev_val);
      rmu_pkg::OP_PUSH:       val_next = FIRST ? cmd.data : prev_val;
      rmu_pkg::OP_POP_INSERT: val_next = next_stay ? next_val :
                                         ((FIRST || stay) ? cmd.data : val);
      default:                val_next = val;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op != rmu_pkg::OP_IDLE) begin
      val <= val_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/rmu_chain.sv
`default_nettype none

module rmu_chain #(
  parameter int unsigned DEPTH   = 512,
  parameter bit          DESCEND = 1'b1,
  parameter int unsigned CNT_W   = 10
) (
  input  wire logic                                clk,
  input  wire rmu_pkg::cell_cmd_t                  cmd,
  input  wire logic [CNT_W-1:0]                    cnt,
  output logic signed [rmu_pkg::DATA_W-1:0]        head
);

  logic signed [rmu_pkg::DATA_W-1:0] vals   [DEPTH];
  logic                              stays  [DEPTH];
  logic signed [rmu_pkg::DATA_W-1:0] prev_v [DEPTH];
  logic                              prev_s [DEPTH];
  logic signed [rmu_pkg::DATA_W-1:0] next_v [DEPTH];
  logic                              next_s [DEPTH];

  // row of cells, each linked to its neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prev_v[i] = '0;
      assign prev_s[i] = 1'b1;
    end else begin : g_mid_prev
      assign prev_v[i] = vals[i-1];
      assign prev_s[i] = stays[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_v[i] = '0;
      assign next_s[i] = 1'b0;
    end else begin : g_mid_next
      assign next_v[i] = vals[i+1];
      assign next_s[i] = stays[i+1];
    end

    rmu_cell #(
      .IDX     (i),
      .DESCEND (DESCEND),
      .CNT_W   (CNT_W)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .cnt       (cnt),
      .prev_val  (prev_v[i]),
      .prev_stay (prev_s[i]),
      .next_val  (next_v[i]),
      .next_stay (next_s[i]),
      .val       (vals[i]),
      .stay      (stays[i])
    );
  end

  assign head = vals[0];

endmodule

`default_nettype wire

FILE: bench/tb.sv
`default_nettype none

module tb;

  localparam int unsigned CAPACITY     = 1024;
  localparam int unsigned RANDOM_ITEMS = 2000;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned DRAIN_CYCLES = 8;
  // long output stall to back the block up into its input
  localparam int unsigned HOLD_AT      = 400;
  localparam int unsigned HOLD_CYCLES  = 300;

  typedef struct packed {
    logic signed [rmu_pkg::DATA_W-1:0] median_floor;
    logic                              median_half;
    logic [rmu_pkg::STORED_W-1:0]      stored_count;
    logic                              overflow;
  } median_t;

  // one directed request, with a hand-written result where fixed_exp is set
  typedef struct packed {
    logic [rmu_pkg::DATA_W-1:0] sample;
    logic                       fixed_exp;
    median_t                    golden;
  } stim_row_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [rmu_pkg::DATA_W-1:0]      s_tdata = '0;   // [31:0] sample
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  // [31:0] median_floor, [32] median_half, [43:33] stored_count, [44] overflow
  logic [rmu_pkg::OUT_TDATA_W-1:0] m_tdata;

  // ascending copy of every sample the block holds
  int          held_samples[$];
  median_t     pending_medians[$];
  stim_row_t   dir_rows[$];
  logic [rmu_pkg::DATA_W-1:0] last_sample = '0;
  int          errors = 0;
  int          results_seen = 0;
  int          stall_left = 0;
  bit          hold_done = 1'b0;
  int          cycle_count = 0;

  running_median_unit #(.CAPACITY(CAPACITY)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // reset
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  // insert a sample into the held set and work out the new median
  function automatic median_t next_median(input logic signed [rmu_pkg::DATA_W-1:0] v);
    median_t r;
    int      pos;
    int      n;
    longint  mid_sum;
    r.overflow = (held_samples.size() >= CAPACITY);
    if (!r.overflow) begin
      pos = 0;
      while (pos < held_samples.size() && held_samples[pos] <= v) pos++;
      held_samples.insert(pos, v);
    end
    n = held_samples.size();
    r.stored_count = rmu_pkg::STORED_W'(n);
    if (n % 2 == 1) begin
      // odd count: top of the lower half
      r.median_floor = held_samples[(n - 1) / 2];
      r.median_half  = 1'b0;
    end else begin
      // even count: exact mean of the two middle samples
      mid_sum = longint'(held_samples[n / 2 - 1]) + longint'(held_samples[n / 2]);
      r.median_half  = mid_sum[0];
      r.median_floor = rmu_pkg::DATA_W'(mid_sum >>> 1);
    end
    return r;
  endfunction

  // mostly no gap, some short ones, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // mix of full-range values, extremes, duplicates and runs near the last value
  function automatic logic [rmu_pkg::DATA_W-1:0] pick_sample();
    logic [rmu_pkg::DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5:       v = $urandom_range(0, 8) - 4;
      6: begin
        if ($urandom_range(0, 1) == 1) v = 32'h7FFF_FFFF - $urandom_range(0, 2);
        else v = 32'h8000_0000 + $urandom_range(0, 2);
      end
      7, 8:       v = last_sample + $urandom_range(0, 16) - 8;
      default:    v = $urandom_range(0, 2000) - 1000;
    endcase
    last_sample = v;
    return v;
  endfunction

  task automatic add_row(input logic [rmu_pkg::DATA_W-1:0] sample, input logic fixed_exp,
                         input logic [rmu_pkg::DATA_W-1:0] fl, input logic half,
                         input int count, input logic ovf);
    stim_row_t row;
    row.sample              = sample;
    row.fixed_exp           = fixed_exp;
    row.golden.median_floor = fl;
    row.golden.median_half  = half;
    row.golden.stored_count = rmu_pkg::STORED_W'(count);
    row.golden.overflow     = ovf;
    dir_rows.push_back(row);
  endtask

  // sender: directed table, then random samples
  initial begin : stimulus
    int        idx;
    int        gap;
    stim_row_t row;
    median_t   predicted;

    // first requests after reset, results read off by hand
    add_row(32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b0, 1, 1'b0);
    add_row(32'h8000_0000, 1'b1, 32'hFFFF_FFFF, 1'b1, 2, 1'b0);
    add_row(32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, 3, 1'b0);
    add_row(32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, 4, 1'b0);
    add_row(32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0, 5, 1'b0);
    // duplicates, extremes and alternating bit patterns
    add_row(32'hFFFF_FFFF, 1'b0, '0, 1'b0, 0, 1'b0);
    add_row(32'h0000_0001, 1'b0, '0, 1'b0, 0, 1'b0);
    add_row(32'h0000_0005, 1'b0, '0, 1'b0, 0, 1'b0);
    add_row(32'h0000_0005, 1'b0, '0, 1'b0, 0, 1'b0);
    add_row(32'h0000_0005, 1'b0, '0, 1'b0, 0, 1'b0);
    add_row(32'h8000_0000, 1'b0, '0, 1'b0, 0, 1'b0);
    add_row(32'h8000_0000, 1'b0, '0, 1'b0, 0, 1'b0);
    add_row(32'h7FFF_FFFF, 1'b0, '0, 1'b0, 0, 1'b0);
    add_row(32'h7FFF_FFFF, 1'b0, '0, 1'b0, 0, 1'b0);
    add_row(32'h7FFF_FFFE, 1'b0, '0, 1'b0, 0, 1'b0);
    add_row(32'h8000_0001, 1'b0, '0, 1'b0, 0, 1'b0);
    add_row(32'h5555_5555, 1'b0, '0, 1'b0, 0, 1'b0);
    add_row(32'hAAAA_AAAA, 1'b0, '0, 1'b0, 0, 1'b0);
    add_row(32'h0000_0003, 1'b0, '0, 1'b0, 0, 1'b0);
    add_row(32'hFFFF_FFFD, 1'b0, '0, 1'b0, 0, 1'b0);
    add_row(32'h0001_0000, 1'b0, '0, 1'b0, 0, 1'b0);
    add_row(32'hFFFF_0000, 1'b0, '0, 1'b0, 0, 1'b0);

    while (rst) @(posedge clk);

    // store fills up part way through the random part, the rest overflows
    for (idx = 0; idx < dir_rows.size() + RANDOM_ITEMS; idx++) begin
      if (idx < dir_rows.size()) begin
        row = dir_rows[idx];
      end else begin
        row = '0;
        row.sample = pick_sample();
      end
      gap = ((idx % 500) >= 200 && (idx % 500) < 260) ? 0 : pick_gap();
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= row.sample;
      @(posedge clk);
      while (!s_tready) @(posedge clk);
      predicted = next_median(row.sample);
      pending_medians.push_back(row.fixed_exp ? row.golden : predicted);
    end
    s_tvalid <= 1'b0;

    // drain
    while (pending_medians.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // receiver: check each result request and drive m_tready
  always @(posedge clk) begin : result_check
    median_t got;
    median_t want;
    int      gap;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.median_floor = m_tdata[rmu_pkg::DATA_W-1:0];
        got.median_half  = m_tdata[rmu_pkg::DATA_W];
        got.stored_count = m_tdata[rmu_pkg::DATA_W+rmu_pkg::STORED_W:rmu_pkg::DATA_W+1];
        got.overflow     = m_tdata[rmu_pkg::DATA_W+rmu_pkg::STORED_W+1];
        if (pending_medians.size() == 0) begin
          $display("%0t unexpected result: expected none, actual %h", $time, m_tdata);
          errors = errors + 1;
        end else begin
          want = pending_medians.pop_front();
          if (got.median_floor !== want.median_floor) begin
            $display("%0t median_floor: expected %0d, actual %0d", $time,
                     want.median_floor, got.median_floor);
            errors = errors + 1;
          end
          if (got.median_half !== want.median_half) begin
            $display("%0t median_half: expected %0b, actual %0b", $time,
                     want.median_half, got.median_half);
            errors = errors + 1;
          end
          if (got.stored_count !== want.stored_count) begin
            $display("%0t stored_count: expected %0d, actual %0d", $time,
                     want.stored_count, got.stored_count);
            errors = errors + 1;
          end
          if (got.overflow !== want.overflow) begin
            $display("%0t overflow: expected %0b, actual %0b", $time,
                     want.overflow, got.overflow);
            errors = errors + 1;
          end
        end
        results_seen <= results_seen + 1;
      end

      // output stalls: one long hold, quiet stretches, random gaps otherwise
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_tready   <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done  <= 1'b1;
        stall_left <= HOLD_CYCLES - 1;
        m_tready   <= 1'b0;
      end else if ((results_seen % 500) >= 100 && (results_seen % 500) < 160) begin
        m_tready <= 1'b1;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          m_tready   <= 1'b0;
          stall_left <= gap - 1;
        end else begin
          m_tready <= 1'b1;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule

`default_nettype wire
